>>> design/wcs_pkg.sv
package wcs_pkg;

	// message kinds on the inbound channel; code 7 has no meaning and is dropped
	typedef enum logic [2:0] {
		KIND_TICK    = 3'd0,
		KIND_ACK     = 3'd1,
		KIND_REQUEST = 3'd2,
		KIND_STATUS  = 3'd3,
		KIND_ABORT   = 3'd4,
		KIND_START   = 3'd5,
		KIND_STOP    = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ACT_ANNOUNCE     = 3'd0,
		ACT_SIG_ANNOUNCE = 3'd1,
		ACT_CHUNK_UNI    = 3'd2,
		ACT_CHUNK_BCAST  = 3'd3,
		ACT_ABORT_UNI    = 3'd4,
		ACT_ABORT_BCAST  = 3'd5,
		ACT_DONE_OK      = 3'd6,
		ACT_FAILED       = 3'd7
	} act_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CHUNK_COUNT     = 3'd0,
		REG_SESSION_TAG     = 3'd1,
		REG_WITH_SIGNATURE  = 3'd2,
		REG_ACK_TIMEOUT     = 3'd3,
		REG_RETRY_LIMIT     = 3'd4,
		REG_ANNOUNCE_PERIOD = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT0,
		ST_EMIT1,
		ST_WINDOW
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] msg_session;
		logic [15:0] msg_next_seq;
		logic        msg_success;
		logic [47:0] src_node;
	} msg_t;

	typedef struct packed {
		act_t        action;
		logic [47:0] dest_node;
		logic [15:0] chunk_seq;
		logic [15:0] session_out;
		logic        last_of_run;
	} res_t;

	localparam logic [15:0] RST_ACK_TIMEOUT     = 16'd2000;
	localparam logic [7:0]  RST_RETRY_LIMIT     = 8'd5;
	localparam logic [15:0] RST_ANNOUNCE_PERIOD = 16'd5000;

endpackage

>>> design/windowed_chunk_sender.sv
// windowed chunk sender: sender side of a go-back-n chunk transfer
//
// msg channel (msg_valid / msg_stall / msg) carries ticks, acks, requests,
// status, abort, start and stop messages; a request is taken at an edge with
// msg_valid high and msg_stall low. res channel (res_valid / res_stall / res)
// carries the resulting announces, chunk sends, aborts and the final outcome;
// last_of_run marks the final result caused by one message.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the six
// registers; cfg_ready is always high, so every write is accepted.
// a message is latched, decoded in the next cycle (ST_EXEC), and its first
// result is loaded into the output register from ST_EMIT0 or ST_WINDOW once
// the output slot is free. msg_stall stays high from the latch until the
// last result of the message is loaded, so no new message is taken before
// then; one that gives no result stalls only for its decode. a window burst
// sends one chunk per cycle while the output slot is free.
// when the receiver holds res_stall the output register keeps its result and
// the sequencer waits; no result is dropped or repeated.
// reset returns the registers to their defaults, ends any session and clears
// the output valid flag; no clearing pass is needed.
module windowed_chunk_sender #(
	parameter int WINDOW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_stall,
	input  wcs_pkg::msg_t  msg,
	output logic           res_valid,
	input  logic           res_stall,
	output wcs_pkg::res_t  res,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import wcs_pkg::*;

	localparam int CNT_W = $clog2(WINDOW + 1);

	// configuration registers
	logic [15:0] chunk_count_q;
	logic [15:0] session_tag_q;
	logic        with_signature_q;
	logic [15:0] ack_timeout_q;
	logic [7:0]  retry_limit_q;
	logic [15:0] announce_period_q;

	// session state
	logic        active_q;
	logic        has_rx_q;
	logic [47:0] rx_addr_q;
	logic [15:0] next_q;
	logic [15:0] acked_q;
	logic [7:0]  retries_q;
	logic [15:0] since_q;

	// sequencer
	state_t           state_q, state_d;
	msg_t             item_q;
	res_t             r0_q, r1_q;
	logic             two_q;
	logic [CNT_W-1:0] cnt_q;

	logic res_valid_q;
	res_t res_q;

	// decode results for the latched message
	logic        ex_active, ex_has_rx;
	logic [47:0] ex_rx_addr;
	logic [15:0] ex_next, ex_acked, ex_since;
	logic [7:0]  ex_retries;
	res_t        ex_r0, ex_r1;
	logic        ex_one, ex_two, ex_win;

	logic        match;
	logic [16:0] elapsed;
	logic [8:0]  new_retries;

	// output side
	logic slot_free;
	logic load_res;
	res_t res_d;
	logic win_last;

	assign cfg_ready = 1'b1;
	assign msg_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign slot_free = !res_valid_q || !res_stall;

	assign match       = active_q && (item_q.msg_session == session_tag_q);
	assign elapsed     = {1'b0, since_q} + 17'd1;
	assign new_retries = {1'b0, retries_q} + 9'd1;

	// window burst ends on the last slot of the window or the last chunk
	assign win_last = (cnt_q == CNT_W'(WINDOW - 1)) ||
		(({1'b0, next_q} + 17'd1) >= {1'b0, chunk_count_q});

	// message decode: next session state and up to two fixed results
	always_comb begin
		ex_active  = active_q;
		ex_has_rx  = has_rx_q;
		ex_rx_addr = rx_addr_q;
		ex_next    = next_q;
		ex_acked   = acked_q;
		ex_retries = retries_q;
		ex_since   = since_q;
		ex_r0      = '{action: ACT_ANNOUNCE, dest_node: '0, chunk_seq: '0,
			session_out: session_tag_q, last_of_run: 1'b1};
		ex_r1      = ex_r0;
		ex_one     = 1'b0;
		ex_two     = 1'b0;
		ex_win     = 1'b0;
		unique case (item_q.kind)
			KIND_TICK: begin
				ex_since = elapsed[16] ? 16'hFFFF : elapsed[15:0];
				if (active_q && !has_rx_q) begin
					// repeat the announce until someone connects
					if (elapsed > {1'b0, announce_period_q}) begin
						ex_one                = 1'b1;
						ex_two                = with_signature_q;
						ex_r0.last_of_run     = !with_signature_q;
						ex_r1.action          = ACT_SIG_ANNOUNCE;
						ex_since              = '0;
					end
				end else if (active_q && (next_q > acked_q)) begin
					if (elapsed > {1'b0, ack_timeout_q}) begin
						ex_retries = new_retries[8] ? 8'hFF : new_retries[7:0];
						ex_one     = 1'b1;
						if (new_retries > {1'b0, retry_limit_q}) begin
							// out of retries: abort and report failure
							ex_r0.action      = ACT_ABORT_UNI;
							ex_r0.dest_node   = rx_addr_q;
							ex_r0.last_of_run = 1'b0;
							ex_r1.action      = ACT_FAILED;
							ex_two            = 1'b1;
							ex_active         = 1'b0;
						end else begin
							// go back to the acked chunk
							ex_next         = acked_q;
							ex_r0.action    = ACT_CHUNK_UNI;
							ex_r0.dest_node = rx_addr_q;
							ex_r0.chunk_seq = acked_q;
							ex_since        = '0;
						end
					end
				end
			end
			KIND_ACK: begin
				if (match) begin
					ex_acked   = item_q.msg_next_seq;
					ex_retries = '0;
					ex_win     = next_q < chunk_count_q;
				end
			end
			KIND_REQUEST: begin
				if (match) begin
					if (!has_rx_q) begin
						ex_rx_addr = item_q.src_node;
						ex_has_rx  = 1'b1;
					end
					ex_next    = item_q.msg_next_seq;
					ex_retries = '0;
					ex_win     = item_q.msg_next_seq < chunk_count_q;
				end
			end
			KIND_STATUS: begin
				if (match) begin
					ex_active    = 1'b0;
					ex_one       = 1'b1;
					ex_r0.action = item_q.msg_success ? ACT_DONE_OK : ACT_FAILED;
				end
			end
			KIND_ABORT: begin
				if (match) begin
					ex_active = 1'b0;
				end
			end
			KIND_START: begin
				if (!active_q) begin
					ex_active         = 1'b1;
					ex_has_rx         = 1'b0;
					ex_rx_addr        = '0;
					ex_next           = '0;
					ex_acked          = '0;
					ex_retries        = '0;
					ex_since          = '0;
					ex_one            = 1'b1;
					ex_two            = with_signature_q;
					ex_r0.last_of_run = !with_signature_q;
					ex_r1.action      = ACT_SIG_ANNOUNCE;
				end
			end
			KIND_STOP: begin
				if (active_q) begin
					ex_active = 1'b0;
					ex_one    = 1'b1;
					if (has_rx_q) begin
						ex_r0.action    = ACT_ABORT_UNI;
						ex_r0.dest_node = rx_addr_q;
					end else begin
						ex_r0.action = ACT_ABORT_BCAST;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (ex_win)      state_d = ST_WINDOW;
				else if (ex_one) state_d = ST_EMIT0;
				else             state_d = ST_IDLE;
			end
			ST_EMIT0: begin
				if (slot_free) state_d = two_q ? ST_EMIT1 : ST_IDLE;
			end
			ST_EMIT1: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_WINDOW: begin
				if (slot_free && win_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output register load
	always_comb begin
		load_res = 1'b0;
		res_d    = r0_q;
		unique case (state_q)
			ST_EMIT0: begin
				load_res = slot_free;
				res_d    = r0_q;
			end
			ST_EMIT1: begin
				load_res = slot_free;
				res_d    = r1_q;
			end
			ST_WINDOW: begin
				load_res          = slot_free;
				res_d.action      = has_rx_q ? ACT_CHUNK_UNI : ACT_CHUNK_BCAST;
				res_d.dest_node   = has_rx_q ? rx_addr_q : '0;
				res_d.chunk_seq   = next_q;
				res_d.session_out = session_tag_q;
				res_d.last_of_run = win_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res)       res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_res) res_q <= res_d;
		if (state_q == ST_IDLE && msg_valid) item_q <= msg;
		if (state_q == ST_EXEC) begin
			r0_q  <= ex_r0;
			r1_q  <= ex_r1;
			two_q <= ex_two;
		end
	end

	// session state and the window step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			has_rx_q  <= 1'b0;
			rx_addr_q <= '0;
			next_q    <= '0;
			acked_q   <= '0;
			retries_q <= '0;
			since_q   <= '0;
			cnt_q     <= '0;
		end else if (state_q == ST_EXEC) begin
			active_q  <= ex_active;
			has_rx_q  <= ex_has_rx;
			rx_addr_q <= ex_rx_addr;
			next_q    <= ex_next;
			acked_q   <= ex_acked;
			retries_q <= ex_retries;
			since_q   <= ex_since;
			cnt_q     <= '0;
		end else if (state_q == ST_WINDOW && slot_free) begin
			next_q  <= next_q + 16'd1;
			since_q <= '0;
			cnt_q   <= cnt_q + CNT_W'(1);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q     <= '0;
			session_tag_q     <= '0;
			with_signature_q  <= 1'b0;
			ack_timeout_q     <= RST_ACK_TIMEOUT;
			retry_limit_q     <= RST_RETRY_LIMIT;
			announce_period_q <= RST_ANNOUNCE_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHUNK_COUNT:     chunk_count_q     <= cfg_data;
				REG_SESSION_TAG:     session_tag_q     <= cfg_data;
				REG_WITH_SIGNATURE:  with_signature_q  <= cfg_data[0];
				REG_ACK_TIMEOUT:     ack_timeout_q     <= cfg_data;
				REG_RETRY_LIMIT:     retry_limit_q     <= cfg_data[7:0];
				REG_ANNOUNCE_PERIOD: announce_period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

>>> design/wcs_checker.sv
module wcs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          msg_valid,
	input logic          msg_stall,
	input logic          res_valid,
	input logic          res_stall,
	input wcs_pkg::res_t res
);
	import wcs_pkg::*;

	// a held result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// a taken request keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_stall |=> msg_stall)
		else $error("block took a second request back to back");

	// more results of the same run still to come, so no new request
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last_of_run |-> msg_stall)
		else $error("request taken in the middle of a run");

	// outcome and broadcast abort always close a run
	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.action == ACT_DONE_OK || res.action == ACT_FAILED ||
		res.action == ACT_ABORT_BCAST) |-> res.last_of_run)
		else $error("session end not marked last");

endmodule

bind windowed_chunk_sender wcs_checker u_wcs_checker (.*);
